// ===== rtl/core/utf8_to_ucs2_decoder_unit_defines.svh =====
// Assertion macros for the UTF-8 to UCS-2 decoder checker
`ifndef UTF8_TO_UCS2_DECODER_UNIT_DEFINES_SVH
`define UTF8_TO_UCS2_DECODER_UNIT_DEFINES_SVH

// ante holds -> cons holds in the same cycle
`define U8U2_CHECK(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// a stalled item keeps its payload on the next cycle
`define U8U2_HOLD(lbl, vld, rdy, dat, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) \
		(vld && !rdy) |=> (vld && $stable(dat))) else $error(msg);

`endif

// ===== rtl/core/u8u2_pkg.sv =====
// Types and constants shared by the UTF-8 to UCS-2 decoder
package u8u2_pkg;

	localparam int BYTE_W = 8;
	localparam int UNIT_W = 16;
	localparam int FIFO_DEPTH = 4;
	localparam logic [UNIT_W-1:0] MAX_UNITS_RST = 16'd255;

	// one queue entry: the results caused by one byte
	typedef struct packed {
		logic [UNIT_W-1:0] code;
		logic [UNIT_W-1:0] count;
		logic              has_unit;
		logic              has_end;
	} cmd_t;

endpackage

// ===== rtl/core/u8u2_front.sv =====
// Front end: accepts bytes, tracks sequence state and issues result commands
module u8u2_front #(
	parameter int COUNT_BITS = 16
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [u8u2_pkg::UNIT_W-1:0]    cfg_wdata,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic [u8u2_pkg::BYTE_W-1:0]    in_byte,
	input  logic                           q_full,
	output logic                           q_push,
	output u8u2_pkg::cmd_t                 q_cmd
);

	localparam int CW = (COUNT_BITS > u8u2_pkg::UNIT_W) ? COUNT_BITS : u8u2_pkg::UNIT_W;

	logic [1:0]                     pend_q, pend_n;
	logic [u8u2_pkg::UNIT_W-1:0]    part_q, part_n, merged;
	logic [COUNT_BITS-1:0]          units_q, units_n, units_inc;
	logic                           disc_q, disc_n;
	logic [u8u2_pkg::UNIT_W-1:0]    max_q;
	logic [CW-1:0]                  done_ext, inc_ext, max_ext;
	logic                           take;

	assign in_ready  = !q_full;
	assign take      = in_valid && in_ready;
	assign units_inc = units_q + 1'b1;
	assign done_ext  = CW'(units_q);
	assign inc_ext   = CW'(units_inc);
	assign max_ext   = CW'(max_q);

	always_comb begin
		pend_n  = pend_q;
		part_n  = part_q;
		units_n = units_q;
		disc_n  = disc_q;
		q_push  = 1'b0;
		q_cmd   = '0;
		merged  = '0;
		if (take) begin
			if (disc_q) begin
				if (in_byte == '0) begin
					disc_n = 1'b0;
				end
			end else if (pend_q != 2'd0) begin
				if (in_byte == '0) begin
					// string ends mid-sequence: flush partial unit, then terminator
					q_push         = 1'b1;
					q_cmd.code     = part_q;
					q_cmd.count    = inc_ext[u8u2_pkg::UNIT_W-1:0];
					q_cmd.has_unit = 1'b1;
					q_cmd.has_end  = 1'b1;
					pend_n         = 2'd0;
					part_n         = '0;
					units_n        = '0;
				end else begin
					pend_n = pend_q - 2'd1;
					if (pend_n == 2'd1) begin
						merged = part_q | {4'b0, in_byte[5:0], 6'b0};
					end else begin
						merged = part_q | {10'b0, in_byte[5:0]};
					end
					if (pend_n != 2'd0) begin
						part_n = merged;
					end else begin
						q_push         = 1'b1;
						q_cmd.code     = merged;
						q_cmd.has_unit = 1'b1;
						part_n         = '0;
						units_n        = units_inc;
					end
				end
			end else if (in_byte == '0) begin
				q_push        = 1'b1;
				q_cmd.count   = done_ext[u8u2_pkg::UNIT_W-1:0];
				q_cmd.has_end = 1'b1;
				units_n       = '0;
			end else if (done_ext >= max_ext) begin
				// capacity reached
				q_push        = 1'b1;
				q_cmd.count   = done_ext[u8u2_pkg::UNIT_W-1:0];
				q_cmd.has_end = 1'b1;
				units_n       = '0;
				disc_n        = 1'b1;
			end else if (!in_byte[7]) begin
				q_push         = 1'b1;
				q_cmd.code     = {8'b0, in_byte};
				q_cmd.has_unit = 1'b1;
				units_n        = units_inc;
			end else if (!in_byte[5]) begin
				part_n = {5'b0, in_byte[4:0], 6'b0};
				pend_n = 2'd1;
			end else begin
				part_n = {in_byte[3:0], 12'b0};
				pend_n = 2'd2;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q  <= '0;
			part_q  <= '0;
			units_q <= '0;
			disc_q  <= 1'b0;
			max_q   <= u8u2_pkg::MAX_UNITS_RST;
		end else begin
			pend_q  <= pend_n;
			part_q  <= part_n;
			units_q <= units_n;
			disc_q  <= disc_n;
			if (cfg_we) begin
				max_q <= cfg_wdata;
			end
		end
	end

endmodule

// ===== rtl/core/u8u2_fifo.sv =====
// Short command queue between front and back end
module u8u2_fifo (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  u8u2_pkg::cmd_t push_cmd,
	output logic           full,
	input  logic           pop,
	output logic           empty,
	output u8u2_pkg::cmd_t head
);

	localparam int AW = $clog2(u8u2_pkg::FIFO_DEPTH);

	u8u2_pkg::cmd_t mem [u8u2_pkg::FIFO_DEPTH];
	logic [AW-1:0]  wr_q, rd_q;
	logic [AW:0]    cnt_q;

	assign full  = (cnt_q == (AW+1)'(u8u2_pkg::FIFO_DEPTH));
	assign empty = (cnt_q == '0);
	assign head  = mem[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem[wr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= rd_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

// ===== rtl/core/u8u2_back.sv =====
// Back end: expands queued commands into result items in an output register
module u8u2_back (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        q_empty,
	input  u8u2_pkg::cmd_t              q_head,
	output logic                        q_pop,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [u8u2_pkg::UNIT_W-1:0] out_code,
	output logic [u8u2_pkg::UNIT_W-1:0] out_count,
	output logic                        out_end,
	output logic                        out_last
);

	logic vld_q;
	logic phase_q;
	logic load;
	logic emit_unit;

	assign load      = !vld_q || out_ready;
	assign emit_unit = q_head.has_unit && !phase_q;
	assign q_pop     = load && !q_empty && !(emit_unit && q_head.has_end);
	assign out_valid = vld_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q   <= 1'b0;
			phase_q <= 1'b0;
		end else if (load) begin
			vld_q <= !q_empty;
			if (!q_empty) begin
				phase_q <= emit_unit && q_head.has_end;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load && !q_empty) begin
			if (emit_unit) begin
				out_code  <= q_head.code;
				out_count <= '0;
				out_end   <= 1'b0;
				out_last  <= !q_head.has_end;
			end else begin
				out_code  <= '0;
				out_count <= q_head.count;
				out_end   <= 1'b1;
				out_last  <= 1'b1;
			end
		end
	end

endmodule

// ===== rtl/core/utf8_to_ucs2_decoder_unit.sv =====
// UTF-8 to UCS-2 decoder top level
//
//  port group   dir  payload (low bit first)
//  s_t*         in   tdata: in_byte[7:0]
//  m_t*         out  tdata: code_unit[15:0], unit_count[31:16]; tuser: is_end; tlast: last
//  cfg_*        in   max_units[15:0]
//
// One byte accepted per cycle while the queue is not full; a result is queued, then loaded into the output register.
// A NUL inside a multi-byte sequence gives two items; the back end emits the unit and then
// the terminator from one queue entry while the 4-entry queue keeps taking bytes.
// Reset clears all sequence state and loads max_units with 255.
// s_tready falls only when the queue is full; m_tready low stalls the output register.
module utf8_to_ucs2_decoder_unit #(
	parameter int COUNT_BITS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [15:0] cfg_wdata,   // max_units
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,     // in_byte
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,     // code_unit[15:0], unit_count[31:16]
	output logic        m_tuser,     // is_end
	output logic        m_tlast
);

	logic           q_push, q_full, q_pop, q_empty;
	u8u2_pkg::cmd_t q_cmd, q_head;
	logic [15:0]    code, count;

	u8u2_front #(.COUNT_BITS(COUNT_BITS)) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.in_byte   (s_tdata),
		.q_full    (q_full),
		.q_push    (q_push),
		.q_cmd     (q_cmd)
	);

	u8u2_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.push_cmd (q_cmd),
		.full     (q_full),
		.pop      (q_pop),
		.empty    (q_empty),
		.head     (q_head)
	);

	u8u2_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_empty   (q_empty),
		.q_head    (q_head),
		.q_pop     (q_pop),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_code  (code),
		.out_count (count),
		.out_end   (m_tuser),
		.out_last  (m_tlast)
	);

	assign m_tdata = {count, code};

endmodule

// ===== rtl/core/u8u2_checker.sv =====
// Port-level checks for the UTF-8 to UCS-2 decoder, bound to the top level
`include "utf8_to_ucs2_decoder_unit_defines.svh"

module u8u2_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [31:0] m_tdata,
	input logic        m_tuser,
	input logic        m_tlast
);

	`U8U2_HOLD(a_out_hold, m_tvalid, m_tready, {m_tdata, m_tuser, m_tlast}, "output item changed while stalled")
	`U8U2_CHECK(a_end_code_zero, m_tvalid && m_tuser, m_tdata[15:0] == 16'd0, "terminator with nonzero code")
	`U8U2_CHECK(a_unit_count_zero, m_tvalid && !m_tuser, m_tdata[31:16] == 16'd0, "unit with nonzero count")
	`U8U2_CHECK(a_end_is_last, m_tvalid && !m_tlast, !m_tuser, "terminator not marked last")

endmodule

bind utf8_to_ucs2_decoder_unit u8u2_checker u_chk (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser),
	.m_tlast  (m_tlast)
);
